// ===== hw/rtl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types, codes and constants of the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // apb register port
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned REG_IDX_LSB = 2;

  // worst-case number of sequencer phases that can finish in one tick
  localparam int unsigned STEPS = 6;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_BUS_FREE    = 3'd0,
    REG_START_HOLD  = 3'd1,
    REG_DATA_HOLD   = 3'd2,
    REG_DATA_SETUP  = 3'd3,
    REG_CLOCK_HIGH  = 3'd4,
    REG_STOP_SETUP  = 3'd5
  } reg_idx_e;

  // command codes
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_STOP  = 2'd3
  } op_e;

  // sequencer phases, one-hot
  typedef enum logic [19:0] {
    PH_IDLE     = 20'h00001,
    PH_ST_BEGIN = 20'h00002,
    PH_ST_SDA   = 20'h00004,
    PH_ST_SCL   = 20'h00008,
    PH_WR_BIT   = 20'h00010,
    PH_WR_DATA  = 20'h00020,
    PH_WR_RISE  = 20'h00040,
    PH_WR_FALL  = 20'h00080,
    PH_WR_REL   = 20'h00100,
    PH_WR_ACKR  = 20'h00200,
    PH_WR_ACKS  = 20'h00400,
    PH_RD_BEGIN = 20'h00800,
    PH_RD_RISE  = 20'h01000,
    PH_RD_SAMP  = 20'h02000,
    PH_RD_ACK   = 20'h04000,
    PH_RD_ARISE = 20'h08000,
    PH_RD_AFALL = 20'h10000,
    PH_RD_END   = 20'h20000,
    PH_SP_BEGIN = 20'h40000,
    PH_SP_END   = 20'h80000
  } phase_e;

  // bus timing in ticks
  typedef struct packed {
    logic [7:0] bus_free_time;
    logic [7:0] start_hold_time;
    logic [7:0] data_hold_time;
    logic [7:0] data_setup_time;
    logic [7:0] clock_high_time;
    logic [7:0] stop_setup_time;
  } cfg_t;

  // one tick word
  typedef struct packed {
    logic       command_valid;
    logic [1:0] operation;
    logic [7:0] write_byte;
    logic       send_ack;
    logic       sda_sampled;
  } cmd_t;

  // one result word
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_received;
  } res_t;

  // sequencer state
  typedef struct packed {
    phase_e     phase;
    logic [3:0] bit_count;
    logic [7:0] wait_count;
    logic [7:0] shift_reg;
    logic       ack_choice;
    logic       ack_flag;
    logic       scl_out;
    logic       sda_out;
    logic [7:0] last_read;
  } seq_state_t;

endpackage

// ===== hw/rtl/i2cm_if.sv =====
// ----------------------------------------------------------------------------
// i2cm_cmd_if / i2cm_res_if
// Valid/ready channels for tick words in and result words out.
// ----------------------------------------------------------------------------
interface i2cm_cmd_if;
  logic       valid;
  logic       ready;
  logic       command_valid;
  logic [1:0] operation;
  logic [7:0] write_byte;
  logic       send_ack;
  logic       sda_sampled;

  modport source (
    output valid, command_valid, operation, write_byte, send_ack, sda_sampled,
    input  ready
  );
  modport sink (
    input  valid, command_valid, operation, write_byte, send_ack, sda_sampled,
    output ready
  );
endinterface

interface i2cm_res_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_byte;
  logic       ack_received;

  modport source (
    output valid, scl_level, sda_level, busy_res, done_res, read_byte, ack_received,
    input  ready
  );
  modport sink (
    input  valid, scl_level, sda_level, busy_res, done_res, read_byte, ack_received,
    output ready
  );
endinterface

// ===== hw/rtl/i2c_master_byte_engine.sv =====
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// I2C master that sequences SCL and SDA one timing tick per word.
//
// Channels: cmd_i takes one tick word per handshake (an optional start,
// write, read or stop command plus the sampled SDA level); res_o returns
// one result word per tick word with the SCL/SDA levels to drive (1 is
// released), busy and done flags, the last read byte and the last write
// ACK. The APB port sets the six tick delays; change them only while the
// engine is idle. Commands that arrive while a sequence runs are dropped.
// Throughput: one tick word per clock cycle while res_o does not stall.
// A tick word passes from acceptance through the input register and then
// the result register around the sequencer step to its result word.
// Reset: lines released, sequencer idle, timing registers at their defaults.
// A stalled result word holds in the result register; one more tick word
// can still be taken into the input register, after which cmd_i.ready
// drops until res_o is read.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  i2cm_cmd_if.sink                         cmd_i,
  i2cm_res_if.source                       res_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [i2cm_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [i2cm_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [i2cm_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);

  i2cm_pkg::cfg_t cfg;
  i2cm_pkg::cmd_t in_d;
  i2cm_pkg::cmd_t in_q;
  i2cm_pkg::res_t step_res;
  i2cm_pkg::res_t out_q;
  logic           in_valid_q;
  logic           out_valid_q;
  logic           adv;

  // timing registers
  i2cm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // a held word steps when the result register is free or being read
  assign adv         = in_valid_q & (~out_valid_q | res_o.ready);
  assign cmd_i.ready = ~in_valid_q | adv;

  assign in_d.command_valid = cmd_i.command_valid;
  assign in_d.operation     = cmd_i.operation;
  assign in_d.write_byte    = cmd_i.write_byte;
  assign in_d.send_ack      = cmd_i.send_ack;
  assign in_d.sda_sampled   = cmd_i.sda_sampled;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      in_valid_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      in_q <= in_d;
    end
  end

  // bus sequencer
  i2cm_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .step_en_i (adv),
    .cmd_i     (in_q),
    .res_o     (step_res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= step_res;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.scl_level    = out_q.scl_level;
  assign res_o.sda_level    = out_q.sda_level;
  assign res_o.busy_res     = out_q.busy_res;
  assign res_o.done_res     = out_q.done_res;
  assign res_o.read_byte    = out_q.read_byte;
  assign res_o.ack_received = out_q.ack_received;

  // every sequencer step leaves a word in the result register
  a_step_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("sequencer step did not produce a result word");

  // a tick word that cannot step is held unchanged
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !adv) |=> (in_valid_q && $stable(in_q)))
    else $error("stalled tick word lost or changed");

  // a finished sequence never reports busy on the same word
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.done_res && out_q.busy_res))
    else $error("done and busy both set in one result word");

endmodule

// ===== hw/rtl/i2cm_regs.sv =====
// ----------------------------------------------------------------------------
// i2cm_regs
// APB register file holding the six bus timing values.
// ----------------------------------------------------------------------------
module i2cm_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [i2cm_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [i2cm_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [i2cm_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output i2cm_pkg::cfg_t                    cfg_o
);

  i2cm_pkg::cfg_t     cfg_q;
  i2cm_pkg::reg_idx_e reg_idx;
  logic               wr_en;
  logic [7:0]         rd_val;

  assign reg_idx = i2cm_pkg::reg_idx_e'(
                     paddr[i2cm_pkg::APB_ADDR_W-1:i2cm_pkg::REG_IDX_LSB]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bus_free_time   <= 8'd5;
      cfg_q.start_hold_time <= 8'd4;
      cfg_q.data_hold_time  <= 8'd1;
      cfg_q.data_setup_time <= 8'd1;
      cfg_q.clock_high_time <= 8'd5;
      cfg_q.stop_setup_time <= 8'd4;
    end else if (wr_en) begin
      unique case (reg_idx)
        i2cm_pkg::REG_BUS_FREE:   cfg_q.bus_free_time   <= pwdata[7:0];
        i2cm_pkg::REG_START_HOLD: cfg_q.start_hold_time <= pwdata[7:0];
        i2cm_pkg::REG_DATA_HOLD:  cfg_q.data_hold_time  <= pwdata[7:0];
        i2cm_pkg::REG_DATA_SETUP: cfg_q.data_setup_time <= pwdata[7:0];
        i2cm_pkg::REG_CLOCK_HIGH: cfg_q.clock_high_time <= pwdata[7:0];
        i2cm_pkg::REG_STOP_SETUP: cfg_q.stop_setup_time <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register reads, unmapped addresses read zero
  always_comb begin
    unique case (reg_idx)
      i2cm_pkg::REG_BUS_FREE:   rd_val = cfg_q.bus_free_time;
      i2cm_pkg::REG_START_HOLD: rd_val = cfg_q.start_hold_time;
      i2cm_pkg::REG_DATA_HOLD:  rd_val = cfg_q.data_hold_time;
      i2cm_pkg::REG_DATA_SETUP: rd_val = cfg_q.data_setup_time;
      i2cm_pkg::REG_CLOCK_HIGH: rd_val = cfg_q.clock_high_time;
      i2cm_pkg::REG_STOP_SETUP: rd_val = cfg_q.stop_setup_time;
      default:                  rd_val = 8'd0;
    endcase
  end

  assign prdata = {{(i2cm_pkg::APB_DATA_W-8){1'b0}}, rd_val};
  assign cfg_o  = cfg_q;

endmodule

// ===== hw/rtl/i2cm_core.sv =====
// ----------------------------------------------------------------------------
// i2cm_core
// Bus sequencer: holds the phase state and advances it by one tick per
// step, running through every phase whose delay has run out.
// ----------------------------------------------------------------------------
module i2cm_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  i2cm_pkg::cfg_t cfg_i,
  input  logic           step_en_i,
  input  i2cm_pkg::cmd_t cmd_i,
  output i2cm_pkg::res_t res_o
);

  typedef struct packed {
    i2cm_pkg::seq_state_t st;
    logic                 done;
  } step_t;

  i2cm_pkg::seq_state_t state_q;
  i2cm_pkg::seq_state_t state_d;
  i2cm_pkg::seq_state_t entry_st;
  i2cm_pkg::seq_state_t chain_st [i2cm_pkg::STEPS+1];
  step_t                step_r   [i2cm_pkg::STEPS];
  logic [i2cm_pkg::STEPS-1:0] chain_done;

  // one phase action; bit loops with all-zero delays finish in a single burst
  function automatic step_t act_step(input i2cm_pkg::seq_state_t s,
                                     input i2cm_pkg::cfg_t c,
                                     input logic sda_in);
    step_t      r;
    logic [3:0] bc_inc;
    logic [3:0] rem;
    logic       fast_wr;
    r.st    = s;
    r.done  = 1'b0;
    bc_inc  = s.bit_count + 4'd1;
    rem     = i2cm_pkg::BITS_PER_BYTE - s.bit_count;
    fast_wr = (c.data_hold_time == 8'd0) && (c.data_setup_time == 8'd0) &&
              (c.clock_high_time == 8'd0);
    if (s.phase != i2cm_pkg::PH_IDLE && s.wait_count == 8'd0) begin
      unique case (s.phase)
        i2cm_pkg::PH_ST_BEGIN: begin
          r.st.sda_out    = 1'b1;
          r.st.scl_out    = 1'b1;
          r.st.phase      = i2cm_pkg::PH_ST_SDA;
          r.st.wait_count = c.bus_free_time;
        end
        i2cm_pkg::PH_ST_SDA: begin
          r.st.sda_out    = 1'b0;
          r.st.phase      = i2cm_pkg::PH_ST_SCL;
          r.st.wait_count = c.start_hold_time;
        end
        i2cm_pkg::PH_ST_SCL: begin
          r.st.scl_out = 1'b0;
          r.done       = 1'b1;
        end
        i2cm_pkg::PH_WR_BIT: begin
          if (fast_wr) begin
            // all remaining bits in one go, the last one stays on sda
            r.st.sda_out    = s.shift_reg[s.bit_count[2:0]];
            r.st.shift_reg  = s.shift_reg << rem;
            r.st.scl_out    = 1'b0;
            r.st.bit_count  = i2cm_pkg::BITS_PER_BYTE;
            r.st.phase      = i2cm_pkg::PH_WR_REL;
            r.st.wait_count = 8'd0;
          end else begin
            r.st.phase      = i2cm_pkg::PH_WR_DATA;
            r.st.wait_count = c.data_hold_time;
          end
        end
        i2cm_pkg::PH_WR_DATA: begin
          r.st.sda_out    = s.shift_reg[7];
          r.st.shift_reg  = {s.shift_reg[6:0], 1'b0};
          r.st.phase      = i2cm_pkg::PH_WR_RISE;
          r.st.wait_count = c.data_setup_time;
        end
        i2cm_pkg::PH_WR_RISE: begin
          r.st.scl_out    = 1'b1;
          r.st.phase      = i2cm_pkg::PH_WR_FALL;
          r.st.wait_count = c.clock_high_time;
        end
        i2cm_pkg::PH_WR_FALL: begin
          r.st.scl_out    = 1'b0;
          r.st.bit_count  = bc_inc;
          r.st.phase      = (bc_inc < i2cm_pkg::BITS_PER_BYTE) ? i2cm_pkg::PH_WR_BIT
                                                               : i2cm_pkg::PH_WR_REL;
          r.st.wait_count = 8'd0;
        end
        i2cm_pkg::PH_WR_REL: begin
          r.st.sda_out    = 1'b1;
          r.st.phase      = i2cm_pkg::PH_WR_ACKR;
          r.st.wait_count = c.data_hold_time;
        end
        i2cm_pkg::PH_WR_ACKR: begin
          r.st.scl_out    = 1'b1;
          r.st.phase      = i2cm_pkg::PH_WR_ACKS;
          r.st.wait_count = c.clock_high_time;
        end
        i2cm_pkg::PH_WR_ACKS: begin
          r.st.ack_flag = ~sda_in;
          r.st.scl_out  = 1'b0;
          r.st.sda_out  = sda_in;
          r.done        = 1'b1;
        end
        i2cm_pkg::PH_RD_BEGIN: begin
          r.st.sda_out    = 1'b1;
          r.st.phase      = i2cm_pkg::PH_RD_RISE;
          r.st.wait_count = c.clock_high_time;
        end
        i2cm_pkg::PH_RD_RISE: begin
          if (c.clock_high_time == 8'd0) begin
            // every remaining bit samples the same level this tick
            r.st.shift_reg  = (s.shift_reg << rem) |
                              (sda_in ? (8'hFF >> s.bit_count) : 8'h00);
            r.st.scl_out    = 1'b0;
            r.st.bit_count  = i2cm_pkg::BITS_PER_BYTE;
            r.st.phase      = i2cm_pkg::PH_RD_ACK;
            r.st.wait_count = 8'd0;
          end else begin
            r.st.scl_out    = 1'b1;
            r.st.phase      = i2cm_pkg::PH_RD_SAMP;
            r.st.wait_count = c.clock_high_time;
          end
        end
        i2cm_pkg::PH_RD_SAMP: begin
          r.st.shift_reg  = {s.shift_reg[6:0], sda_in};
          r.st.scl_out    = 1'b0;
          r.st.bit_count  = bc_inc;
          r.st.phase      = (bc_inc < i2cm_pkg::BITS_PER_BYTE) ? i2cm_pkg::PH_RD_RISE
                                                               : i2cm_pkg::PH_RD_ACK;
          r.st.wait_count = c.clock_high_time;
        end
        i2cm_pkg::PH_RD_ACK: begin
          r.st.sda_out    = ~s.ack_choice;
          r.st.phase      = i2cm_pkg::PH_RD_ARISE;
          r.st.wait_count = c.clock_high_time;
        end
        i2cm_pkg::PH_RD_ARISE: begin
          r.st.scl_out    = 1'b1;
          r.st.phase      = i2cm_pkg::PH_RD_AFALL;
          r.st.wait_count = c.clock_high_time;
        end
        i2cm_pkg::PH_RD_AFALL: begin
          r.st.scl_out    = 1'b0;
          r.st.phase      = i2cm_pkg::PH_RD_END;
          r.st.wait_count = c.clock_high_time;
        end
        i2cm_pkg::PH_RD_END: begin
          r.st.sda_out   = 1'b1;
          r.st.last_read = s.shift_reg;
          r.done         = 1'b1;
        end
        i2cm_pkg::PH_SP_BEGIN: begin
          r.st.sda_out    = 1'b0;
          r.st.scl_out    = 1'b1;
          r.st.phase      = i2cm_pkg::PH_SP_END;
          r.st.wait_count = c.stop_setup_time;
        end
        i2cm_pkg::PH_SP_END: begin
          r.st.sda_out = 1'b1;
          r.done       = 1'b1;
        end
        default: begin
          r.done = 1'b1;
        end
      endcase
      if (r.done) begin
        r.st.phase      = i2cm_pkg::PH_IDLE;
        r.st.wait_count = 8'd0;
      end
    end
    return r;
  endfunction

  // command launch while idle, otherwise count down the running delay
  always_comb begin
    entry_st = state_q;
    if (state_q.phase == i2cm_pkg::PH_IDLE) begin
      if (cmd_i.command_valid) begin
        entry_st.ack_choice = cmd_i.send_ack;
        entry_st.bit_count  = 4'd0;
        entry_st.wait_count = 8'd0;
        unique case (i2cm_pkg::op_e'(cmd_i.operation))
          i2cm_pkg::OP_START: entry_st.phase = i2cm_pkg::PH_ST_BEGIN;
          i2cm_pkg::OP_WRITE: begin
            entry_st.shift_reg = cmd_i.write_byte;
            entry_st.phase     = i2cm_pkg::PH_WR_BIT;
          end
          i2cm_pkg::OP_READ: begin
            entry_st.shift_reg = 8'd0;
            entry_st.phase     = i2cm_pkg::PH_RD_BEGIN;
          end
          i2cm_pkg::OP_STOP:  entry_st.phase = i2cm_pkg::PH_SP_BEGIN;
        endcase
      end
    end else if (state_q.wait_count != 8'd0) begin
      entry_st.wait_count = state_q.wait_count - 8'd1;
    end
  end

  // chain of phase actions for this tick
  assign chain_st[0] = entry_st;
  for (genvar g = 0; g < i2cm_pkg::STEPS; g++) begin : g_step
    assign step_r[g]     = act_step(chain_st[g], cfg_i, cmd_i.sda_sampled);
    assign chain_st[g+1] = step_r[g].st;
    assign chain_done[g] = step_r[g].done;
  end

  assign state_d = chain_st[i2cm_pkg::STEPS];

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase      <= i2cm_pkg::PH_IDLE;
      state_q.bit_count  <= 4'd0;
      state_q.wait_count <= 8'd0;
      state_q.shift_reg  <= 8'd0;
      state_q.ack_choice <= 1'b0;
      state_q.ack_flag   <= 1'b0;
      state_q.scl_out    <= 1'b1;
      state_q.sda_out    <= 1'b1;
      state_q.last_read  <= 8'd0;
    end else if (step_en_i) begin
      state_q <= state_d;
    end
  end

  // result word for this tick
  assign res_o.scl_level    = state_d.scl_out;
  assign res_o.sda_level    = state_d.sda_out;
  assign res_o.busy_res     = (state_d.phase != i2cm_pkg::PH_IDLE);
  assign res_o.done_res     = |chain_done;
  assign res_o.read_byte    = state_d.last_read;
  assign res_o.ack_received = state_d.ack_flag;

endmodule
